### rtl/nid_pkg.sv
// shared constants, codes and types of the numeric integrator and differentiator
package nid_pkg;

    localparam int F         = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 48;
    localparam int DT_W      = 31;
    localparam int CS_W      = 36;
    localparam int CW        = CS_W - 1;
    localparam int PW        = CW + DT_W;
    localparam int QW        = (PW - F > CS_W + F) ? PW - F : CS_W + F;
    localparam int SW        = QW + 2;
    localparam int DIVW      = DATA_W;
    localparam int CNT_W     = $clog2(QW);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRULE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRULE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT    = 3'd6;

    localparam logic MODE_INT  = 1'b0;
    localparam logic MODE_DIFF = 1'b1;

    localparam logic [1:0] IR_RECT = 2'd0;
    localparam logic [1:0] IR_TRAP = 2'd1;
    localparam logic [1:0] IR_SIMP = 2'd2;
    localparam logic [1:0] IR_QUAD = 2'd3;

    localparam logic [1:0] DR_TWO  = 2'd0;
    localparam logic [1:0] DR_BACK = 2'd1;
    localparam logic [1:0] DR_FWD  = 2'd2;

    localparam logic [DIVW-1:0] DIV_RECT = 32'd1;
    localparam logic [DIVW-1:0] DIV_TRAP = 32'd2;
    localparam logic [DIVW-1:0] DIV_SIMP = 32'd6;
    localparam logic [DIVW-1:0] DIV_QUAD = 32'd12;

    localparam logic [DT_W-1:0]          DT_RESET = DT_W'(1) << F;
    localparam logic signed [SW-1:0]     ACC_HI   =
        {{(SW - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [SW-1:0]     ACC_LO   = ~ACC_HI;
    localparam logic signed [DATA_W-1:0] OUT_MAX  = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] OUT_MIN  = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_COEF,
        S_SETUP,
        S_MUL,
        S_PREP,
        S_DIV,
        S_ACC,
        S_SAT,
        S_CLAMP,
        S_DSAT,
        S_DONE
    } t_state;

endpackage

### rtl/numeric_integrator_differentiator.sv
// numeric integrator and differentiator top level, bit-serial multiply and divide
// integrate: per beat 31 multiplier steps and 52 divider steps, plus coef, setup, prep, acc, sat and clamp states
// differentiate: per beat 52 divider steps; zero or unused-rule results skip the divider
// result register holds the beat while the next input is accepted; input taken only when idle
// synchronous active-low reset restores register defaults and clears accumulator and history
module numeric_integrator_differentiator
    import nid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [DATA_W-1:0]    i_s_axis_tdata,   // sample[31:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [DATA_W-1:0]    o_m_axis_tdata,   // value[31:0]
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_state r_state, n_state;

    logic                     r_mode, n_mode;
    logic [1:0]               r_irule, n_irule;
    logic [1:0]               r_drule, n_drule;
    logic [DT_W-1:0]          r_dt, n_dt;
    logic signed [DATA_W-1:0] r_sat_min, n_sat_min;
    logic signed [DATA_W-1:0] r_sat_max, n_sat_max;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [DATA_W-1:0] r_prev, n_prev;
    logic signed [DATA_W-1:0] r_old, n_old;
    logic                     r_out_valid, n_out_valid;
    logic [CNT_W-1:0]         r_cnt, n_cnt;

    logic signed [DATA_W-1:0] r_samp, n_samp;
    logic signed [CS_W-1:0]   r_coef, n_coef;
    logic                     r_neg, n_neg;
    logic                     r_zero, n_zero;
    logic [DIVW-1:0]          r_div, n_div;
    logic [CW-1:0]            r_mcand, n_mcand;
    logic [PW-1:0]            r_prod, n_prod;
    logic [QW-1:0]            r_quo, n_quo;
    logic [DIVW-1:0]          r_rem, n_rem;
    logic signed [SW-1:0]     r_sum, n_sum;
    logic signed [DATA_W-1:0] r_res, n_res;
    logic [DATA_W-1:0]        r_out, n_out;

    logic                     s_accept;
    logic signed [CS_W-1:0]   s_sx, s_px, s_ox;
    logic [CW-1:0]            s_mag;
    logic [CW:0]              s_msum;
    logic [PW-1:0]            s_tsum;
    logic [DIVW:0]            s_trial;
    logic signed [SW-1:0]     s_qx;
    logic signed [SW-1:0]     s_inc;
    logic signed [ACC_W-1:0]  s_min_x, s_max_x;
    logic                     s_big;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    assign s_sx    = {{(CS_W - DATA_W){r_samp[DATA_W-1]}}, r_samp};
    assign s_px    = {{(CS_W - DATA_W){r_prev[DATA_W-1]}}, r_prev};
    assign s_ox    = {{(CS_W - DATA_W){r_old[DATA_W-1]}}, r_old};
    assign s_mag   = r_neg ? CW'(-r_coef) : CW'(r_coef);
    assign s_msum  = {1'b0, r_prod[PW-1:DT_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
    assign s_tsum  = r_prod + (PW'(r_div) << (F - 1));
    assign s_trial = {r_rem, r_quo[QW-1]} - {1'b0, r_div};
    assign s_qx    = {2'b00, r_quo};
    assign s_inc   = r_neg ? -s_qx : s_qx;
    assign s_min_x = ACC_W'(r_sat_min);
    assign s_max_x = ACC_W'(r_sat_max);
    assign s_big   = r_neg ? ((|r_quo[QW-1:DATA_W]) ||
                              (r_quo[DATA_W-1] && (|r_quo[DATA_W-2:0])))
                           : (|r_quo[QW-1:DATA_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_INT;
            r_irule     <= IR_RECT;
            r_drule     <= DR_TWO;
            r_dt        <= DT_RESET;
            r_sat_min   <= OUT_MIN;
            r_sat_max   <= OUT_MAX;
            r_acc       <= '0;
            r_prev      <= '0;
            r_old       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_irule     <= n_irule;
            r_drule     <= n_drule;
            r_dt        <= n_dt;
            r_sat_min   <= n_sat_min;
            r_sat_max   <= n_sat_max;
            r_acc       <= n_acc;
            r_prev      <= n_prev;
            r_old       <= n_old;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_samp  <= n_samp;
        r_coef  <= n_coef;
        r_neg   <= n_neg;
        r_zero  <= n_zero;
        r_div   <= n_div;
        r_mcand <= n_mcand;
        r_prod  <= n_prod;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_sum   <= n_sum;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_irule     = r_irule;
        n_drule     = r_drule;
        n_dt        = r_dt;
        n_sat_min   = r_sat_min;
        n_sat_max   = r_sat_max;
        n_acc       = r_acc;
        n_prev      = r_prev;
        n_old       = r_old;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_samp      = r_samp;
        n_coef      = r_coef;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_div       = r_div;
        n_mcand     = r_mcand;
        n_prod      = r_prod;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_sum       = r_sum;
        n_res       = r_res;
        n_out       = r_out;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_samp  = i_s_axis_tdata;
                    n_state = S_COEF;
                end
            end
            S_COEF: begin
                n_zero = 1'b0;
                if (r_mode == MODE_INT) begin
                    unique case (r_irule)
                        IR_RECT: begin
                            n_coef = s_sx;
                            n_div  = DIV_RECT;
                        end
                        IR_TRAP: begin
                            n_coef = s_sx + s_px;
                            n_div  = DIV_TRAP;
                        end
                        IR_SIMP: begin
                            n_coef = s_sx + (s_px <<< 2) + s_ox;
                            n_div  = DIV_SIMP;
                        end
                        default: begin
                            n_coef = (s_sx <<< 2) + s_sx + (s_px <<< 3) - s_ox;
                            n_div  = DIV_QUAD;
                        end
                    endcase
                end else begin
                    n_div = {r_dt, 1'b0};
                    unique case (r_drule)
                        DR_TWO: begin
                            n_coef = s_sx - s_px;
                            n_div  = {1'b0, r_dt};
                        end
                        DR_BACK: begin
                            n_coef = (s_sx <<< 1) + s_sx - (s_px <<< 2) + s_ox;
                        end
                        DR_FWD: begin
                            n_coef = (s_px <<< 2) - (s_ox <<< 1) - s_ox - s_sx;
                        end
                        default: begin
                            n_coef = '0;
                            n_zero = 1'b1;
                        end
                    endcase
                end
                n_neg   = n_coef[CS_W-1];
                n_old   = r_prev;
                n_prev  = r_samp;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_cnt = '0;
                n_rem = '0;
                if (r_mode == MODE_INT) begin
                    n_mcand = s_mag;
                    n_prod  = {{CW{1'b0}}, r_dt};
                    n_state = S_MUL;
                end else if (r_zero || (r_coef == '0)) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else if (r_dt == '0) begin
                    n_res   = r_neg ? OUT_MIN : OUT_MAX;
                    n_state = S_DONE;
                end else begin
                    n_quo   = {{(QW - CW - F){1'b0}}, s_mag, {F{1'b0}}} + QW'(r_div >> 1);
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                n_prod = {s_msum, r_prod[DT_W-1:1]};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DT_W - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_quo   = QW'(s_tsum >> F);
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!s_trial[DIVW]) begin
                    n_rem = s_trial[DIVW-1:0];
                end else begin
                    n_rem = {r_rem[DIVW-2:0], r_quo[QW-1]};
                end
                n_quo = {r_quo[QW-2:0], ~s_trial[DIVW]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_state = (r_mode == MODE_INT) ? S_ACC : S_DSAT;
                end
            end
            S_ACC: begin
                n_sum   = SW'(r_acc) + s_inc;
                n_state = S_SAT;
            end
            S_SAT: begin
                if (r_sum > ACC_HI) begin
                    n_acc = ACC_HI[ACC_W-1:0];
                end else if (r_sum < ACC_LO) begin
                    n_acc = ACC_LO[ACC_W-1:0];
                end else begin
                    n_acc = r_sum[ACC_W-1:0];
                end
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_acc > s_max_x) begin
                    n_res = r_sat_max;
                end else if (r_acc < s_min_x) begin
                    n_res = r_sat_min;
                end else begin
                    n_res = r_acc[DATA_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DSAT: begin
                if (s_big) begin
                    n_res = r_neg ? OUT_MIN : OUT_MAX;
                end else begin
                    n_res = r_neg ? -r_quo[DATA_W-1:0] : r_quo[DATA_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:    n_mode    = i_cfg_data[0];
                CFG_IRULE:   n_irule   = i_cfg_data[1:0];
                CFG_DRULE:   n_drule   = i_cfg_data[1:0];
                CFG_DT:      n_dt      = i_cfg_data[DT_W-1:0];
                CFG_SAT_MIN: n_sat_min = i_cfg_data;
                CFG_SAT_MAX: n_sat_max = i_cfg_data;
                CFG_INIT: begin
                    n_acc  = ACC_W'($signed(i_cfg_data));
                    n_prev = i_cfg_data;
                    n_old  = i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_COEF && !o_s_axis_tready))
        else $error("input accepted but block did not start work");

    a_init_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_INIT) |=>
            (r_acc == ACC_W'($past($signed(i_cfg_data))) && r_prev == $past(i_cfg_data)
             && r_old == $past(i_cfg_data)))
        else $error("initial value not loaded into state");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP && r_sat_min <= r_sat_max) |=>
            (r_res >= $past(r_sat_min) && r_res <= $past(r_sat_max)))
        else $error("integrator result outside clamp window");

endmodule
